### design/rlsc_pkg.sv
// Shared types and constants for the resistive load setpoint controller.
`default_nettype none
package rlsc_pkg;
    localparam int TABLE_DEPTH  = 1024;
    localparam int SWITCH_COUNT = 13;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int RES_W        = 24;
    localparam int MASK_W       = 13;
    localparam int ENT_W        = 11;
    localparam int QUO_W        = 25;
    localparam logic [RES_W-1:0] R_MAX = 24'hFFFFFF;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_MEAS  = 2'd2;
    localparam logic [1:0] OP_DISC  = 2'd3;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_SETTLED = 3'd1;
    localparam logic [2:0] ST_GAVEUP  = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_DISC    = 3'd4;

    localparam logic [2:0] CFG_GAIN   = 3'd0;
    localparam logic [2:0] CFG_TOL    = 3'd1;
    localparam logic [2:0] CFG_SETTLE = 3'd2;
    localparam logic [2:0] CFG_MAXATT = 3'd3;
    localparam logic [2:0] CFG_ENTRIES = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic take;        // latch input item
        logic tbl_write;   // write table entry
        logic start;       // load target/setpoint, clear counters
        logic disc;        // stop run
        logic meas_begin;  // bump attempts, check validity
        logic div_start;
        logic div_step;
        logic update;      // apply R, settle hit or correction
        logic srch_start;
        logic srch_step;
        logic out_load;    // load result register
        logic [2:0] out_status;
        logic out_applied; // use applied mask instead of search result
        logic stop_run;
        logic out_zero_meas;
    } rlsc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic running;
        logic valid_rd;
        logic div_done;
        logic srch_done;
        logic settled;
        logic gave_up;
    } rlsc_stat_t;
endpackage
`default_nettype wire

### design/rlsc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module rlsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### design/rlsc_datapath.sv
// Datapath: table, search, divider, setpoint update and result register.
`default_nettype none
module rlsc_datapath
    import rlsc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rlsc_cmd_t        cmd,
    output rlsc_stat_t            stat,
    input  wire logic [1:0]       in_op,
    input  wire logic [IDX_W-1:0] in_idx,
    input  wire logic [RES_W-1:0] in_res,
    input  wire logic [MASK_W-1:0] in_mask,
    input  wire logic [RES_W-1:0] in_target,
    input  wire logic [16:0]      in_mv,
    input  wire logic [17:0]      in_ma,
    input  wire logic [8:0]       gain_k,
    input  wire logic [15:0]      tolerance,
    input  wire logic [7:0]       settle_count,
    input  wire logic [7:0]       max_attempts,
    input  wire logic [ENT_W-1:0] entries_used,
    output logic [MASK_W-1:0]     o_mask,
    output logic                  o_load_on,
    output logic [2:0]            o_status,
    output logic [RES_W-1:0]      o_meas,
    output logic [7:0]            o_attempts
);
    logic [1:0]        op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [RES_W-1:0]  res_reg, target_in_reg;
    logic [MASK_W-1:0] wmask_reg;
    logic [16:0]       mv_reg;
    logic [17:0]       ma_reg;

    logic [RES_W-1:0] setpoint_reg, target_reg, meas_reg;
    logic [7:0]       attempts_reg, hits_reg;
    logic             running_reg, enable_reg, valid_reg;
    logic [MASK_W-1:0] applied_reg;

    // search
    logic [CNT_W-1:0]  scnt_reg;
    logic              have_reg, rvalid_reg;
    logic [RES_W-1:0]  bdiff_reg;
    logic [MASK_W-1:0] bmask_reg;
    logic [CNT_W-1:0]  n_lim;
    logic [IDX_W-1:0]  raddr;
    logic [RES_W-1:0]  t_res;
    logic [MASK_W-1:0] t_mask;
    logic              srch_done;

    // divider
    logic [QUO_W-1:0]  quo_reg;
    logic [17:0]       rem_reg;
    logic [24:0]       dvd_reg;
    logic [4:0]        dcnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg        <= in_op;
            idx_reg       <= in_idx;
            res_reg       <= in_res;
            wmask_reg     <= in_mask;
            target_in_reg <= in_target;
            mv_reg        <= in_mv;
            ma_reg        <= in_ma;
        end
    end

    assign n_lim = (entries_used < ENT_W'(TABLE_DEPTH)) ? CNT_W'(entries_used)
                                                         : CNT_W'(TABLE_DEPTH);
    assign raddr = cmd.tbl_write ? idx_reg : scnt_reg[IDX_W-1:0];

    rlsc_ram #(.WIDTH(RES_W), .DEPTH(TABLE_DEPTH)) u_res (
        .clk(clk), .we(cmd.tbl_write), .addr(raddr), .wdata(res_reg), .rdata(t_res));
    rlsc_ram #(.WIDTH(MASK_W), .DEPTH(TABLE_DEPTH)) u_mask (
        .clk(clk), .we(cmd.tbl_write), .addr(raddr), .wdata(wmask_reg), .rdata(t_mask));

    logic [RES_W-1:0] d_cur;
    assign d_cur = (t_res > setpoint_reg) ? t_res - setpoint_reg : setpoint_reg - t_res;
    assign srch_done = (scnt_reg >= n_lim) && !rvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scnt_reg   <= '0;
            rvalid_reg <= 1'b0;
            have_reg   <= 1'b0;
            bdiff_reg  <= '0;
            bmask_reg  <= '0;
        end
        else if (cmd.srch_start)
        begin
            scnt_reg   <= '0;
            rvalid_reg <= 1'b0;
            have_reg   <= 1'b0;
            bmask_reg  <= '0;
        end
        else if (cmd.srch_step)
        begin
            rvalid_reg <= scnt_reg < n_lim;
            if (scnt_reg < n_lim)
            begin
                scnt_reg <= scnt_reg + 1'b1;
            end
            if (rvalid_reg && (!have_reg || d_cur < bdiff_reg))
            begin
                have_reg  <= 1'b1;
                bdiff_reg <= d_cur;
                bmask_reg <= t_mask & MASK_W'((1 << SWITCH_COUNT) - 1);
            end
        end
    end

    // restoring divider: (mv << 8) / ma, one quotient bit a cycle
    logic [18:0] trial;
    assign trial = {rem_reg, dvd_reg[24]} - {1'b0, ma_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dvd_reg  <= {mv_reg, 8'd0};
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= 5'd25;
        end
        else if (cmd.div_step && dcnt_reg != 5'd0)
        begin
            dvd_reg  <= {dvd_reg[23:0], 1'b0};
            dcnt_reg <= dcnt_reg - 1'b1;
            if (!trial[18])
            begin
                rem_reg <= trial[17:0];
                quo_reg <= {quo_reg[23:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[16:0], dvd_reg[24]};
                quo_reg <= {quo_reg[23:0], 1'b0};
            end
        end
    end

    logic signed [18:0] ma_s;
    logic               rd_ok;
    assign ma_s  = 19'(signed'(ma_reg));
    assign rd_ok = !(mv_reg < 17'd10 || mv_reg > 17'd100000 ||
                     ma_s < 19'sd1 || ma_s > 19'sd100000);

    logic [RES_W-1:0] q_sat, mag;
    logic             err_neg;
    logic [32:0]      prod;
    logic [RES_W:0]   sp_up;
    logic [RES_W-1:0] delta;
    assign q_sat   = quo_reg[24] ? R_MAX : quo_reg[RES_W-1:0];
    assign err_neg = q_sat > target_reg;
    assign mag     = err_neg ? q_sat - target_reg : target_reg - q_sat;
    assign prod    = 33'(gain_k) * 33'(mag);
    assign delta   = prod[31:8];
    assign sp_up   = {1'b0, setpoint_reg} + {1'b0, delta};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            target_reg   <= '0;
            attempts_reg <= '0;
            hits_reg     <= '0;
            running_reg  <= 1'b0;
            enable_reg   <= 1'b0;
            valid_reg    <= 1'b0;
            applied_reg  <= '0;
            meas_reg     <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                target_reg   <= target_in_reg;
                setpoint_reg <= target_in_reg;
                attempts_reg <= '0;
                hits_reg     <= '0;
                running_reg  <= 1'b1;
                enable_reg   <= 1'b1;
            end
            if (cmd.disc)
            begin
                running_reg <= 1'b0;
                enable_reg  <= 1'b0;
            end
            if (cmd.meas_begin)
            begin
                if (attempts_reg != 8'd255)
                begin
                    attempts_reg <= attempts_reg + 1'b1;
                end
                valid_reg   <= rd_ok;
                applied_reg <= bmask_reg;
                meas_reg    <= '0;
            end
            if (cmd.update)
            begin
                meas_reg <= q_sat;
                if (mag <= RES_W'(tolerance))
                begin
                    if (hits_reg != 8'd255)
                    begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                end
                else if (err_neg)
                begin
                    setpoint_reg <= (delta > setpoint_reg) ? '0 : setpoint_reg - delta;
                end
                else
                begin
                    setpoint_reg <= sp_up[RES_W] ? R_MAX : sp_up[RES_W-1:0];
                end
            end
            if (cmd.stop_run)
            begin
                running_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_mask     <= cmd.out_applied ? applied_reg :
                          (cmd.out_status == ST_DISC ? '0 : bmask_reg);
            o_load_on  <= cmd.disc ? 1'b0 : enable_reg;
            o_status   <= cmd.out_status;
            o_meas     <= cmd.out_zero_meas ? '0 : meas_reg;
            o_attempts <= attempts_reg;
        end
    end

    assign stat.op        = op_reg;
    assign stat.running   = running_reg;
    assign stat.valid_rd  = valid_reg;
    assign stat.div_done  = (dcnt_reg == 5'd0);
    assign stat.srch_done = srch_done;
    assign stat.settled   = valid_reg && (hits_reg >= settle_count);
    assign stat.gave_up   = attempts_reg >= max_attempts;
endmodule
`default_nettype wire

### design/rlsc_ctrl.sv
// Controller state machine sequencing table writes, search and measurement.
`default_nettype none
module rlsc_ctrl
    import rlsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire rlsc_stat_t stat,
    output rlsc_cmd_t       cmd
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DEC    = 9'b000000010,
        S_SRCH0  = 9'b000000100,
        S_SRCH   = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_UPD    = 9'b000100000,
        S_DECIDE = 9'b001000000,
        S_SRCH2  = 9'b010000000,
        S_SRCH3  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   meas_reg, meas_next;

    assign s_tready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        meas_next   = meas_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (stat.op)
                    OP_WRITE:
                    begin
                        cmd.tbl_write = 1'b1;
                        state_next    = S_IDLE;
                    end
                    OP_START:
                    begin
                        cmd.start  = 1'b1;
                        meas_next  = 1'b0;
                        state_next = S_SRCH0;
                    end
                    OP_MEAS:
                    begin
                        if (stat.running)
                        begin
                            meas_next  = 1'b1;
                            state_next = S_SRCH0;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.disc          = 1'b1;
                        cmd.out_load      = 1'b1;
                        cmd.out_status    = ST_DISC;
                        cmd.out_zero_meas = 1'b1;
                        mvalid_next       = 1'b1;
                        state_next        = S_IDLE;
                    end
                endcase
            end
            S_SRCH0:
            begin
                cmd.srch_start = 1'b1;
                state_next     = S_SRCH;
            end
            S_SRCH:
            begin
                cmd.srch_step = 1'b1;
                if (stat.srch_done)
                begin
                    cmd.srch_step = 1'b0;
                    if (meas_reg)
                    begin
                        cmd.meas_begin = 1'b1;
                        cmd.div_start  = 1'b1;
                        state_next     = S_DIV;
                    end
                    else
                    begin
                        cmd.out_load      = 1'b1;
                        cmd.out_status    = ST_NEW;
                        cmd.out_zero_meas = 1'b1;
                        mvalid_next       = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_step = 1'b0;
                    state_next   = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = stat.valid_rd;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (stat.settled)
                begin
                    cmd.stop_run    = 1'b1;
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = ST_SETTLED;
                    cmd.out_applied = 1'b1;
                    mvalid_next     = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (stat.gave_up)
                begin
                    cmd.stop_run    = 1'b1;
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = ST_GAVEUP;
                    cmd.out_applied = 1'b1;
                    mvalid_next     = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (!stat.valid_rd)
                begin
                    cmd.out_load      = 1'b1;
                    cmd.out_status    = ST_INVALID;
                    cmd.out_applied   = 1'b1;
                    cmd.out_zero_meas = 1'b1;
                    mvalid_next       = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    cmd.srch_start = 1'b1;
                    state_next     = S_SRCH2;
                end
            end
            S_SRCH2:
            begin
                cmd.srch_step = 1'b1;
                if (stat.srch_done)
                begin
                    cmd.srch_step = 1'b0;
                    state_next    = S_SRCH3;
                end
            end
            S_SRCH3:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_NEW;
                mvalid_next    = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
            meas_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            meas_reg   <= meas_next;
        end
    end
endmodule
`default_nettype wire

### design/resistive_load_setpoint_controller.sv
// Top level of the resistive load setpoint controller.
// Input items arrive on the s_ stream; op in tuser, the rest packed in tdata.
// op 0 writes a table entry (no result), op 1 starts a run at a target,
// op 2 is a measurement (result only while running), op 3 disconnects.
// Each result goes out on the m_ stream and waits in an output register.
// A start runs one table scan over N = min(entries_used, 1024) entries,
// at one entry per cycle through the table RAM read port. A measurement
// runs one scan for the mask in force, a bit-serial divider, then a
// second scan for the new mask.
// One item is worked on at a time; s_tready is low while busy or while a
// result waits, so a stalled receiver holds the block.
// Reset clears the run state and the registers to their defaults; table
// contents are undefined until written. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must write it while idle, as the block does not enforce this.
`default_nettype none
module resistive_load_setpoint_controller
    import rlsc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // entry_index[9:0], entry_resistance[33:10], entry_mask[46:34],
    // target_resistance[70:47], voltage_mv[87:71], current_ma[105:88]
    input  wire logic [111:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // fet_mask[12:0], load_on[13], status[16:14], measured_resistance[40:17],
    // attempt_count[48:41]
    output logic [55:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    logic [8:0]       gain_reg;
    logic [15:0]      tol_reg;
    logic [7:0]       settle_reg, maxatt_reg;
    logic [ENT_W-1:0] entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= 9'd128;
            tol_reg     <= 16'd51;
            settle_reg  <= 8'd3;
            maxatt_reg  <= 8'd50;
            entries_reg <= ENT_W'(543);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN:    gain_reg    <= cfg_data[8:0];
                CFG_TOL:     tol_reg     <= cfg_data;
                CFG_SETTLE:  settle_reg  <= cfg_data[7:0];
                CFG_MAXATT:  maxatt_reg  <= cfg_data[7:0];
                CFG_ENTRIES: entries_reg <= cfg_data[ENT_W-1:0];
                default:     ;
            endcase
        end
    end

    rlsc_cmd_t  cmd;
    rlsc_stat_t stat;
    logic [MASK_W-1:0] o_mask;
    logic              o_load_on;
    logic [2:0]        o_status;
    logic [RES_W-1:0]  o_meas;
    logic [7:0]        o_att;

    rlsc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .stat(stat), .cmd(cmd));

    rlsc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_op(s_tuser), .in_idx(s_tdata[9:0]), .in_res(s_tdata[33:10]),
        .in_mask(s_tdata[46:34]), .in_target(s_tdata[70:47]),
        .in_mv(s_tdata[87:71]), .in_ma(s_tdata[105:88]),
        .gain_k(gain_reg), .tolerance(tol_reg), .settle_count(settle_reg),
        .max_attempts(maxatt_reg), .entries_used(entries_reg),
        .o_mask(o_mask), .o_load_on(o_load_on), .o_status(o_status),
        .o_meas(o_meas), .o_attempts(o_att));

    assign m_tdata = {7'd0, o_att, o_meas, o_status, o_load_on, o_mask};
endmodule
`default_nettype wire
